>>> hw/rtl/kea_pkg.sv
`timescale 1ns / 1ps

package kea_pkg;

  // Default number of button slots kept in the state.
  localparam int NUM_BUTTONS_DEF = 16;

  // Field widths of the request and result items.
  localparam int MASK_W      = 16;
  localparam int TIME_W      = 32;
  localparam int TYPE_W      = 16;
  localparam int CODE_W      = 16;
  localparam int VALUE_W     = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_ADDR_W  = 1;
  localparam int BTN_IDX_W   = 4;
  localparam int IN_TDATA_W  = TIME_W + TYPE_W + CODE_W + VALUE_W;
  localparam int OUT_TDATA_W = 4 * MASK_W;

  // Request kind carried in tuser.
  typedef enum logic {
    OP_POLL  = 1'b0,
    OP_EVENT = 1'b1
  } op_e;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_DELAY    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_INTERVAL = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] REPEAT_DELAY_RST    = 16'd300;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

  // Event type for key events.
  localparam logic [TYPE_W-1:0] EVT_KEY = 16'd1;

  // Raw key codes of the buttons.
  localparam logic [CODE_W-1:0] KEY_UP      = 16'd103;
  localparam logic [CODE_W-1:0] KEY_DOWN    = 16'd108;
  localparam logic [CODE_W-1:0] KEY_LEFT    = 16'd105;
  localparam logic [CODE_W-1:0] KEY_RIGHT   = 16'd106;
  localparam logic [CODE_W-1:0] KEY_A       = 16'd48;
  localparam logic [CODE_W-1:0] KEY_B       = 16'd30;
  localparam logic [CODE_W-1:0] KEY_X       = 16'd21;
  localparam logic [CODE_W-1:0] KEY_Y       = 16'd45;
  localparam logic [CODE_W-1:0] KEY_START   = 16'd28;
  localparam logic [CODE_W-1:0] KEY_SELECT  = 16'd54;
  localparam logic [CODE_W-1:0] KEY_MENU_A  = 16'd115;
  localparam logic [CODE_W-1:0] KEY_MENU_B  = 16'd114;
  localparam logic [CODE_W-1:0] KEY_L1      = 16'd38;
  localparam logic [CODE_W-1:0] KEY_L2      = 16'd44;
  localparam logic [CODE_W-1:0] KEY_R1      = 16'd19;
  localparam logic [CODE_W-1:0] KEY_R2      = 16'd46;

  // Button lookup result.
  typedef struct packed {
    logic                 hit;
    logic [BTN_IDX_W-1:0] idx;
  } btn_t;

  // Decoded request handed from the decoder to the state update.
  typedef struct packed {
    logic                 poll;
    logic                 press;
    logic                 rel;
    logic [BTN_IDX_W-1:0] idx;
  } evt_t;

  // Maps a raw key code to its button slot.
  function automatic btn_t button_of(input logic [CODE_W-1:0] code);
    btn_t b;
    b.hit = 1'b1;
    case (code)
      KEY_UP:     b.idx = 4'd0;
      KEY_DOWN:   b.idx = 4'd1;
      KEY_LEFT:   b.idx = 4'd2;
      KEY_RIGHT:  b.idx = 4'd3;
      KEY_A:      b.idx = 4'd4;
      KEY_B:      b.idx = 4'd5;
      KEY_X:      b.idx = 4'd6;
      KEY_Y:      b.idx = 4'd7;
      KEY_START:  b.idx = 4'd8;
      KEY_SELECT: b.idx = 4'd9;
      KEY_MENU_A: b.idx = 4'd10;
      KEY_MENU_B: b.idx = 4'd10;
      KEY_L1:     b.idx = 4'd11;
      KEY_L2:     b.idx = 4'd12;
      KEY_R1:     b.idx = 4'd13;
      KEY_R2:     b.idx = 4'd14;
      default: begin
        b.hit = 1'b0;
        b.idx = '0;
      end
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/key_event_autorepeat_top.sv
`timescale 1ns / 1ps

// Button tracker with auto-repeat. Each request is either a poll start
// (tuser low, carrying the millisecond tick) or an input event (tuser high,
// carrying type, code and value); every request yields one result with the
// held, pressed, released and repeated button masks after it is applied.
// A request is registered on acceptance. When the output register is free
// or drains, it is applied to the button state and its result is loaded
// into the output register, so the block takes one request per cycle while
// the output does not stall. While a result waits on a stalled output, the
// input register holds its request and no new request is taken. All repeat
// checks of a poll start are done in parallel, one comparator and one adder
// per button slot. The delay and interval registers may only be written
// while no request is in flight.

module key_event_autorepeat_top #(
  parameter int NUM_BUTTONS = kea_pkg::NUM_BUTTONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [kea_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [kea_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Request stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] time_ms, [47:32] event_type, [63:48] key_code, [95:64] key_value
  input  logic [kea_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] operation
  input  logic                                s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] held_mask, [31:16] pressed_now_mask, [47:32] released_now_mask,
  // [63:48] repeated_now_mask
  output logic [kea_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import kea_pkg::*;

  logic [CFG_W-1:0]         delay_q;
  logic [CFG_W-1:0]         interval_q;
  logic                     in_valid_q;
  op_e                      op_q;
  logic [TIME_W-1:0]        time_q;
  logic [TYPE_W-1:0]        type_q;
  logic [CODE_W-1:0]        code_q;
  logic signed [VALUE_W-1:0] value_q;
  logic                     out_valid_q;
  logic [OUT_TDATA_W-1:0]   out_data_q;
  logic                     step;
  evt_t                     evt;
  logic [NUM_BUTTONS-1:0]   held, pressed, released, repeated;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= REPEAT_DELAY_RST;
      interval_q <= REPEAT_INTERVAL_RST;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_REPEAT_DELAY) begin
        delay_q <= cfg_wdata_i;
      end else if (cfg_addr_i == REG_REPEAT_INTERVAL) begin
        interval_q <= cfg_wdata_i;
      end
    end
  end

  // The held request is applied when the output register is free or drains.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= op_e'(s_axis_tuser);
      time_q  <= s_axis_tdata[31:0];
      type_q  <= s_axis_tdata[47:32];
      code_q  <= s_axis_tdata[63:48];
      value_q <= s_axis_tdata[95:64];
    end
  end

  kea_decode u_decode (
    .op_i         (op_q),
    .event_type_i (type_q),
    .key_code_i   (code_q),
    .key_value_i  (value_q),
    .evt_o        (evt)
  );

  kea_state #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_state (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .evt_i             (evt),
    .time_ms_i         (time_q),
    .repeat_delay_i    (delay_q),
    .repeat_interval_i (interval_q),
    .held_o            (held),
    .pressed_o         (pressed),
    .released_o        (released),
    .repeated_o        (repeated)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {MASK_W'(repeated), MASK_W'(released), MASK_W'(pressed), MASK_W'(held)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A button marked as repeated is always held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[63:48] & ~m_axis_tdata[15:0]) == '0))
    else $error("repeated mask holds a button that is not held");

  // No code maps to the top mask bit, so it never shows up as held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15] == 1'b0))
    else $error("held mask shows the unmapped top button");

  // A registered request with a free output register produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> m_axis_tvalid)
    else $error("registered request produced no result");

endmodule

>>> hw/rtl/kea_decode.sv
`timescale 1ns / 1ps

module kea_decode (
  input  kea_pkg::op_e                        op_i,
  input  logic [kea_pkg::TYPE_W-1:0]          event_type_i,
  input  logic [kea_pkg::CODE_W-1:0]          key_code_i,
  input  logic signed [kea_pkg::VALUE_W-1:0]  key_value_i,
  output kea_pkg::evt_t                       evt_o
);
  import kea_pkg::*;

  btn_t btn;
  logic is_key;
  logic is_zero;
  logic too_big;

  // Classify the request: a key event only counts for a known code and a
  // value of at most one.
  always_comb begin
    btn     = button_of(key_code_i);
    is_key  = (op_i == OP_EVENT) && (event_type_i == EVT_KEY) && btn.hit;
    is_zero = (key_value_i == '0);
    too_big = key_value_i > VALUE_W'(signed'(1));

    evt_o.poll  = (op_i == OP_POLL);
    evt_o.press = is_key && !too_big && !is_zero;
    evt_o.rel   = is_key && is_zero;
    evt_o.idx   = btn.idx;
  end

endmodule

>>> hw/rtl/kea_state.sv
`timescale 1ns / 1ps

module kea_state #(
  parameter int NUM_BUTTONS = kea_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  kea_pkg::evt_t                 evt_i,
  input  logic [kea_pkg::TIME_W-1:0]    time_ms_i,
  input  logic [kea_pkg::CFG_W-1:0]     repeat_delay_i,
  input  logic [kea_pkg::CFG_W-1:0]     repeat_interval_i,
  output logic [NUM_BUTTONS-1:0]        held_o,
  output logic [NUM_BUTTONS-1:0]        pressed_o,
  output logic [NUM_BUTTONS-1:0]        released_o,
  output logic [NUM_BUTTONS-1:0]        repeated_o
);
  import kea_pkg::*;

  logic [NUM_BUTTONS-1:0] held_q, held_d;
  logic [NUM_BUTTONS-1:0] pressed_q, pressed_d;
  logic [NUM_BUTTONS-1:0] released_q, released_d;
  logic [NUM_BUTTONS-1:0] repeated_q, repeated_d;
  logic [TIME_W-1:0]      poll_time_q, poll_time_d;
  logic [TIME_W-1:0]      due_q [NUM_BUTTONS];
  logic [TIME_W-1:0]      due_d [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] btn_oh;
  logic [NUM_BUTTONS-1:0] due_hit;
  logic [TIME_W-1:0]      first_due;

  // Per-button repeat checks run side by side against the polled tick.
  always_comb begin
    btn_oh    = NUM_BUTTONS'(1) << evt_i.idx;
    first_due = poll_time_q + TIME_W'(repeat_delay_i);
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      due_hit[i] = held_q[i] && (time_ms_i >= due_q[i]);
    end
  end

  // Next state for one request.
  always_comb begin
    held_d      = held_q;
    pressed_d   = pressed_q;
    released_d  = released_q;
    repeated_d  = repeated_q;
    poll_time_d = poll_time_q;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      due_d[i] = due_q[i];
    end

    if (evt_i.poll) begin
      poll_time_d = time_ms_i;
      pressed_d   = '0;
      released_d  = '0;
      repeated_d  = due_hit;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (due_hit[i]) begin
          due_d[i] = due_q[i] + TIME_W'(repeat_interval_i);
        end
      end
    end else if (evt_i.rel) begin
      held_d     = held_q & ~btn_oh;
      repeated_d = repeated_q & ~btn_oh;
      released_d = released_q | btn_oh;
    end else if (evt_i.press && ((held_q & btn_oh) == '0)) begin
      // A fresh press; pressing a button already held changes nothing.
      held_d     = held_q | btn_oh;
      pressed_d  = pressed_q | btn_oh;
      repeated_d = repeated_q | btn_oh;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (btn_oh[i]) begin
          due_d[i] = first_due;
        end
      end
    end
  end

  // Control masks and the latched poll tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      pressed_q   <= '0;
      released_q  <= '0;
      repeated_q  <= '0;
      poll_time_q <= '0;
    end else if (step_i) begin
      held_q      <= held_d;
      pressed_q   <= pressed_d;
      released_q  <= released_d;
      repeated_q  <= repeated_d;
      poll_time_q <= poll_time_d;
    end
  end

  // Due times are only read for held buttons, which a press has written.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        due_q[i] <= due_d[i];
      end
    end
  end

  assign held_o     = held_d;
  assign pressed_o  = pressed_d;
  assign released_o = released_d;
  assign repeated_o = repeated_d;

endmodule

>>> dv/tb_key_event_autorepeat_top.sv
`timescale 1ns / 1ps

module tb_key_event_autorepeat_top;
  import kea_pkg::*;

  localparam int          BTN_SLOTS   = 16;
  localparam int          SETTLE_CYC  = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One request as the tracker sees it.
  typedef struct packed {
    op_e         op;
    logic [31:0] time_ms;
    logic [15:0] event_type;
    logic [15:0] key_code;
    logic [31:0] key_value;
  } key_req_t;

  // Result masks, held in the lowest bits as on the result bus.
  typedef struct packed {
    logic [15:0] repeated;
    logic [15:0] released;
    logic [15:0] pressed;
    logic [15:0] held;
  } masks_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Own copy of the button state and the registers.
  logic [15:0] btn_held     = '0;
  logic [15:0] btn_pressed  = '0;
  logic [15:0] btn_released = '0;
  logic [15:0] btn_repeated = '0;
  logic [31:0] btn_due [BTN_SLOTS];
  logic [31:0] latched_tick = '0;
  logic [15:0] cfg_delay    = REPEAT_DELAY_RST;
  logic [15:0] cfg_interval = REPEAT_INTERVAL_RST;

  masks_t      pending_masks [$];
  logic [31:0] tick_now     = '0;
  int          burst_left   = 0;
  int unsigned cycle_count  = 0;
  int          stall_left   = 0;
  int          stall_mode   = 0;

  int n_mismatches = 0;
  int n_checked    = 0;
  int n_polls      = 0;
  int n_presses    = 0;
  int n_releases   = 0;
  int n_repeats    = 0;
  int n_ignored    = 0;
  int n_settings   = 0;

  key_event_autorepeat_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Raw code of each button slot; the menu slot also answers to a second code.
  function automatic logic [15:0] code_of_slot(input int slot);
    case (slot)
      0:       return KEY_UP;
      1:       return KEY_DOWN;
      2:       return KEY_LEFT;
      3:       return KEY_RIGHT;
      4:       return KEY_A;
      5:       return KEY_B;
      6:       return KEY_X;
      7:       return KEY_Y;
      8:       return KEY_START;
      9:       return KEY_SELECT;
      10:      return KEY_MENU_A;
      11:      return KEY_L1;
      12:      return KEY_L2;
      13:      return KEY_R1;
      default: return KEY_R2;
    endcase
  endfunction

  function automatic int slot_of_code(input logic [15:0] code);
    if (code == KEY_MENU_B) return 10;
    for (int s = 0; s < 15; s++) begin
      if (code_of_slot(s) == code) return s;
    end
    return -1;
  endfunction

  // True for a poll start or a key event that acts on a button.
  function automatic bit is_key_action(input key_req_t r);
    if (r.op == OP_POLL) return 1'b1;
    return r.event_type == EVT_KEY && slot_of_code(r.key_code) >= 0 &&
           !(!r.key_value[31] && r.key_value > 32'd1);
  endfunction

  // Applies one request to the tracked state and returns the masks after it.
  function automatic masks_t track_buttons(input key_req_t r);
    int     slot;
    masks_t m;
    if (r.op == OP_POLL) begin
      n_polls++;
      latched_tick = r.time_ms;
      btn_pressed  = '0;
      btn_released = '0;
      btn_repeated = '0;
      for (int i = 0; i < BTN_SLOTS; i++) begin
        if (btn_held[i] && latched_tick >= btn_due[i]) begin
          btn_repeated[i] = 1'b1;
          btn_due[i]      = btn_due[i] + {16'd0, cfg_interval};
          n_repeats++;
        end
      end
    end else if (is_key_action(r)) begin
      slot = slot_of_code(r.key_code);
      if (r.key_value == 32'd0) begin
        n_releases++;
        btn_held[slot]     = 1'b0;
        btn_repeated[slot] = 1'b0;
        btn_released[slot] = 1'b1;
      end else if (!btn_held[slot]) begin
        n_presses++;
        btn_pressed[slot]  = 1'b1;
        btn_repeated[slot] = 1'b1;
        btn_held[slot]     = 1'b1;
        btn_due[slot]      = latched_tick + {16'd0, cfg_delay};
      end
    end else begin
      n_ignored++;
    end
    m.held     = btn_held;
    m.pressed  = btn_pressed;
    m.released = btn_released;
    m.repeated = btn_repeated;
    return m;
  endfunction

  function automatic key_req_t poll_req(input logic [31:0] t);
    key_req_t r;
    r         = key_req_t'({$urandom, $urandom, $urandom});
    r.op      = OP_POLL;
    r.time_ms = t;
    return r;
  endfunction

  function automatic key_req_t key_req(input logic [15:0] kind, input logic [15:0] code,
                                       input logic [31:0] value);
    key_req_t r;
    r            = key_req_t'({$urandom, $urandom, $urandom});
    r.op         = OP_EVENT;
    r.event_type = kind;
    r.key_code   = code;
    r.key_value  = value;
    return r;
  endfunction

  // Next poll tick: mostly forward steps, now and then backwards or anywhere.
  function automatic logic [31:0] next_tick(input int unsigned step_max);
    case ($urandom_range(0, 19))
      0:       tick_now = $urandom;
      1:       tick_now = tick_now - $urandom_range(0, step_max);
      default: tick_now = tick_now + $urandom_range(0, step_max);
    endcase
    return tick_now;
  endfunction

  function automatic logic [15:0] random_button_code();
    int s;
    s = $urandom_range(0, 14);
    if (s == 10 && $urandom_range(0, 1) == 0) return KEY_MENU_B;
    return code_of_slot(s);
  endfunction

  // Mostly polls and well-formed key events, the rest noise.
  function automatic key_req_t make_random_request(input int unsigned step_max);
    int       pick;
    int       vp;
    key_req_t r;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r = poll_req(next_tick(step_max));
    end else if (pick < 85) begin
      vp = $urandom_range(0, 9);
      r  = key_req(EVT_KEY, random_button_code(),
                   vp < 5 ? 32'd1 : vp < 9 ? 32'd0 : ($urandom | 32'h8000_0000));
    end else begin
      case ($urandom_range(0, 3))
        0:       r = key_req(16'($urandom), 16'($urandom), $urandom);
        1:       r = key_req(EVT_KEY, random_button_code(),
                             $urandom_range(0, 1) ? 32'd2 : ($urandom & 32'h7FFF_FFFF));
        2:       r = key_req(16'd3, random_button_code(), 32'd1);
        default: r = key_req(EVT_KEY, 16'($urandom), 32'd1);
      endcase
    end
    return r;
  endfunction

  // Sends one request in bursts with random gaps and records its expected masks.
  task automatic send_request(input key_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {r.key_value, r.key_code, r.event_type, r.time_ms};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_masks.push_back(track_buttons(r));
  endtask

  // Stops sending and waits until every request has been answered.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_masks.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Writes both registers while the block is idle.
  task automatic write_settings(input logic [15:0] delay, input logic [15:0] interval);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_REPEAT_DELAY;
    cfg_wdata_i <= delay;
    @(posedge clk_i);
    cfg_addr_i  <= REG_REPEAT_INTERVAL;
    cfg_wdata_i <= interval;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    cfg_delay    = delay;
    cfg_interval = interval;
    n_settings++;
  endtask

  // Sends the given number of random requests.
  task automatic run_random(input int n_reqs, input int unsigned step_max);
    int       done;
    key_req_t r;
    done = 0;
    while (done < n_reqs) begin
      r = make_random_request(step_max);
      send_request(r);
      done++;
    end
  endtask

  // Extremes of every field and each corner of the press, release and repeat rules,
  // at the reset values of the registers.
  task automatic test_directed_cases();
    send_request(poll_req(32'd0));
    send_request(key_req(EVT_KEY, KEY_UP, 32'd1));
    send_request(key_req(EVT_KEY, KEY_MENU_A, 32'd1));
    // Second menu code while menu is held: nothing changes.
    send_request(key_req(EVT_KEY, KEY_MENU_B, 32'd1));
    send_request(key_req(EVT_KEY, KEY_R2, 32'hFFFF_FFFF));
    send_request(key_req(EVT_KEY, KEY_A, 32'h8000_0000));
    send_request(key_req(EVT_KEY, KEY_B, 32'd2));
    send_request(key_req(EVT_KEY, KEY_X, 32'h7FFF_FFFF));
    send_request(key_req(16'd3, KEY_Y, 32'd1));
    send_request(key_req(16'hFFFF, KEY_Y, 32'd1));
    send_request(key_req(EVT_KEY, 16'hFFFF, 32'd1));
    send_request(key_req(EVT_KEY, 16'h0000, 32'd1));
    // Release of a button that was never held still flags it.
    send_request(key_req(EVT_KEY, KEY_L1, 32'd0));
    send_request(key_req(EVT_KEY, KEY_UP, 32'd1));
    send_request(poll_req(32'd299));
    send_request(poll_req(32'd300));
    send_request(poll_req(32'd399));
    send_request(poll_req(32'd400));
    send_request(key_req(EVT_KEY, KEY_UP, 32'd0));
    send_request(poll_req(32'hFFFF_FFFF));
    send_request(key_req(EVT_KEY, KEY_MENU_B, 32'd0));
    send_request(poll_req(32'd0));
    wait_for_results();
  endtask

  // Due times that cross the top of the tick range.
  task automatic test_time_wrap();
    write_settings(16'd500, 16'd200);
    tick_now = 32'hFFFF_F000;
    run_random(150, 300);
    wait_for_results();
  endtask

  // Several register settings, the extremes among them, each with random traffic
  // and a full drain half way through.
  task automatic test_register_settings();
    logic [15:0] delays    [6];
    logic [15:0] intervals [6];
    delays    = '{16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'($urandom)};
    intervals = '{16'd1, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'($urandom)};
    for (int p = 0; p < 6; p++) begin
      write_settings(delays[p], intervals[p]);
      run_random(125, (int'(delays[p]) + int'(intervals[p])) / 4 + 4);
      wait_for_results();
      run_random(125, (int'(delays[p]) + int'(intervals[p])) / 4 + 4);
      wait_for_results();
    end
  endtask

  // Result side stalls in stretches: always ready, mostly ready, mostly stalled,
  // or a fixed pattern.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_left % 4 != 0);
    endcase
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      n_mismatches++;
      if (n_mismatches <= 10)
        $display("Mismatch on result %0d, %s: expected %04h, got %04h",
                 n_checked, name, want, got);
    end
  endtask

  // Each result is compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_results
    masks_t got;
    masks_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_masks.size() == 0) begin
        n_mismatches++;
        if (n_mismatches <= 10)
          $display("Unexpected result %h with no request outstanding", got);
      end else begin
        want = pending_masks.pop_front();
        compare_field("held_mask", want.held, got.held);
        compare_field("pressed_now_mask", want.pressed, got.pressed);
        compare_field("released_now_mask", want.released, got.released);
        compare_field("repeated_now_mask", want.repeated, got.repeated);
      end
      n_checked++;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_masks.size());
      $display("** key_event_autorepeat_top: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < BTN_SLOTS; i++) btn_due[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_time_wrap();
    test_register_settings();
    wait_for_results();

    n_mismatches = n_mismatches + pending_masks.size();
    $display("Run covered %0d poll starts, %0d presses, %0d releases, %0d auto-repeats",
             n_polls, n_presses, n_releases, n_repeats);
    $display("and %0d ignored events over %0d register settings; %0d results checked.",
             n_ignored, n_settings + 1, n_checked);
    if (n_mismatches == 0) begin
      $display("** key_event_autorepeat_top: PASSED **");
    end else begin
      $display("%0d mismatches in total", n_mismatches);
      $display("** key_event_autorepeat_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/kea_pkg.sv
hw/rtl/kea_decode.sv
hw/rtl/kea_state.sv
hw/rtl/key_event_autorepeat_top.sv
dv/tb_key_event_autorepeat_top.sv
